// ===== sv/mtfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfc_pkg
// Shared types and constants for the move-to-front object cache.
// ----------------------------------------------------------------------------
`default_nettype none

package mtfc_pkg;

  localparam int CACHE_ENTRIES = 64;
  localparam int POS_W         = $clog2(CACHE_ENTRIES);
  localparam int NUM_W         = 23;
  localparam int GEN_W         = 16;
  localparam int HDL_W         = 16;
  localparam int HPOS_W        = 6;

  // Stored payload of one cache slot; the present bit lives apart so it can be reset.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [GEN_W-1:0] gen;
    logic             printing;
    logic             type3;
    logic [HDL_W-1:0] handle;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/mtfc_if.sv =====
// ----------------------------------------------------------------------------
// mtfc_if
// Request and response channels of the object cache (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface mtfc_req_if import mtfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] ref_num;
  logic [GEN_W-1:0] ref_gen;
  logic             printing;
  logic             is_type3;
  logic             create_ok;

  modport source (output valid, ref_num, ref_gen, printing, is_type3, create_ok,
                  input ready);
  modport sink   (input valid, ref_num, ref_gen, printing, is_type3, create_ok,
                  output ready);
endinterface

interface mtfc_rsp_if import mtfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [HPOS_W-1:0] hit_position;
  logic              handle_valid;
  logic [HDL_W-1:0]  handle;
  logic              evicted;
  logic [HDL_W-1:0]  evicted_handle;

  modport source (output valid, hit, hit_position, handle_valid, handle, evicted,
                  evicted_handle, input ready);
  modport sink   (input valid, hit, hit_position, handle_valid, handle, evicted,
                  evicted_handle, output ready);
endinterface

`default_nettype wire

// ===== sv/mtfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtfc_ctrl
// Sequencer: capture request, register compare, then select/shift and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfc_ctrl import mtfc_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.compare = 1'b1;
        state_next  = ST_UPDATE;
      end
      ST_UPDATE: begin
        // commit only once the output register is free
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_next  = ST_MATCH;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit)
      out_valid_next = 1'b1;
    else if (out_ready)
      out_valid_next = 1'b0;
    else
      out_valid_next = out_valid;
  end

endmodule

`default_nettype wire

// ===== sv/mtfc_dpath.sv =====
// ----------------------------------------------------------------------------
// mtfc_dpath
// Entry shift line, per-slot compare, first-hit select and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfc_dpath import mtfc_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  cmd_t               cmd,
  input  wire  [NUM_W-1:0]   ref_num,
  input  wire  [GEN_W-1:0]   ref_gen,
  input  wire                printing,
  input  wire                is_type3,
  input  wire                create_ok,
  output logic               hit,
  output logic [HPOS_W-1:0]  hit_position,
  output logic               handle_valid,
  output logic [HDL_W-1:0]   handle,
  output logic               evicted,
  output logic [HDL_W-1:0]   evicted_handle
);

  entry_t                   ent [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] present;
  logic [CACHE_ENTRIES-1:0] match_now;
  logic [CACHE_ENTRIES-1:0] match_vec;
  logic [CACHE_ENTRIES-1:0] ahead;
  logic [CACHE_ENTRIES-1:0] first;

  logic [NUM_W-1:0] q_num;
  logic [GEN_W-1:0] q_gen;
  logic             q_prt;
  logic             q_t3;
  logic             q_ok;
  logic [HDL_W-1:0] next_handle;

  logic                    any_hit;
  entry_t                  found;
  entry_t                  fresh;
  entry_t                  front;
  logic                    front_present;
  logic [POS_W-1:0]        pos;
  logic [POS_W+HPOS_W-1:0] pos_ext;
  logic [CACHE_ENTRIES-1:0] one_c;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_num <= ref_num;
      q_gen <= ref_gen;
      q_prt <= printing;
      q_t3  <= is_type3;
      q_ok  <= create_ok;
    end
  end

  // A type-3 slot also needs its printing flag to agree.
  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      match_now[i] = present[i] && (ent[i].num == q_num) && (ent[i].gen == q_gen) &&
                     (!ent[i].type3 || (ent[i].printing == q_prt));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare)
      match_vec <= match_now;
  end

  // ahead[i]: some slot nearer the front matched, so slot i holds its place
  always_comb begin
    one_c = {{(CACHE_ENTRIES-1){1'b0}}, 1'b1};
    found = '0;
    pos   = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      ahead[i] = |(match_vec & ((one_c << i) - one_c));
      first[i] = match_vec[i] & ~ahead[i];
      if (first[i]) begin
        found = found | ent[i];
        pos   = pos | POS_W'(i);
      end
    end
  end

  assign any_hit       = |match_vec;
  assign fresh.num     = q_num;
  assign fresh.gen     = q_gen;
  assign fresh.printing = q_prt;
  assign fresh.type3   = q_t3;
  assign fresh.handle  = q_ok ? next_handle : '0;
  assign front         = any_hit ? found : fresh;
  assign front_present = any_hit | q_ok;
  assign pos_ext       = {{HPOS_W{1'b0}}, pos};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ent[0] <= front;
      for (int i = 1; i < CACHE_ENTRIES; i++) begin
        if (!ahead[i])
          ent[i] <= ent[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present     <= '0;
      next_handle <= '0;
    end else if (cmd.commit) begin
      present[0] <= front_present;
      for (int i = 1; i < CACHE_ENTRIES; i++) begin
        if (!ahead[i])
          present[i] <= present[i-1];
      end
      if (!any_hit && q_ok)
        next_handle <= next_handle + HDL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit          <= any_hit;
      hit_position <= any_hit ? pos_ext[HPOS_W-1:0] : '0;
      handle_valid <= front_present;
      handle       <= front.handle;
      if (!any_hit && present[CACHE_ENTRIES-1]) begin
        evicted        <= 1'b1;
        evicted_handle <= ent[CACHE_ENTRIES-1].handle;
      end else begin
        evicted        <= 1'b0;
        evicted_handle <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/move_to_front_object_cache.sv =====
// ----------------------------------------------------------------------------
// move_to_front_object_cache
// Fully associative handle cache kept in most-recently-used order.
// ----------------------------------------------------------------------------
// A request first has the compare of every slot against it registered in
// ST_MATCH; in ST_UPDATE the first match is picked, the slots shift and the
// response register is loaded. A new request can be taken in ST_UPDATE as the
// current one commits, while responses are drained.
// The response register frees the input side until a second response would
// be due. Slot present bits are flip-flops cleared by reset: no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_front_object_cache import mtfc_pkg::*; (
  input wire         clk,
  input wire         rst,
  mtfc_req_if.sink   req,
  mtfc_rsp_if.source rsp
);

  cmd_t cmd;

  mtfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  mtfc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .ref_num        (req.ref_num),
    .ref_gen        (req.ref_gen),
    .printing       (req.printing),
    .is_type3       (req.is_type3),
    .create_ok      (req.create_ok),
    .hit            (rsp.hit),
    .hit_position   (rsp.hit_position),
    .handle_valid   (rsp.handle_valid),
    .handle         (rsp.handle),
    .evicted        (rsp.evicted),
    .evicted_handle (rsp.evicted_handle)
  );

  a_hit_has_handle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.hit |-> rsp.handle_valid && !rsp.evicted)
    else $error("hit response without handle or with eviction");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> rsp.hit_position == '0)
    else $error("miss response with nonzero position");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken during compare cycle");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !rsp.valid || rsp.ready)
    else $error("response overwritten before it was taken");

endmodule

`default_nettype wire
